/* rtl/ucfp_pkg.sv */
// Package for the UART command frame parser.
// Holds event codes, register indexes, reset values and field widths.
// No dependencies; used by the interfaces and the top level.
package ucfp_pkg;

    // Payload capacity of one frame
    localparam int unsigned MAX_PAYLOAD_DEF = 2048;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned INDEX_W = 11;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TMO_W   = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST    = 16'd1000;

    // Input item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DATA   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd2;
    localparam logic [EVENT_W-1:0] EV_REJECT = 2'd3;

endpackage

/* rtl/ucfp_in_if.sv */
// Input channel of the frame parser: one received byte or one ms tick.
// Depends on ucfp_pkg for field widths.
interface ucfp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ucfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

/* rtl/ucfp_out_if.sv */
// Result channel of the frame parser: one event per received byte.
// Depends on ucfp_pkg for field widths.
interface ucfp_out_if;
    logic                          valid;
    logic                          ready;
    logic [ucfp_pkg::EVENT_W-1:0]  event_res;
    logic [ucfp_pkg::BYTE_W-1:0]   payload_byte;
    logic [ucfp_pkg::INDEX_W-1:0]  payload_index;
    logic [ucfp_pkg::BYTE_W-1:0]   command_code;
    logic [ucfp_pkg::BYTE_W-1:0]   direction_code;
    logic [ucfp_pkg::BYTE_W-1:0]   error_code;
    logic [ucfp_pkg::LEN_W-1:0]    payload_length;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output command_code, output direction_code,
                    output error_code, output payload_length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input command_code, input direction_code,
                    input error_code, input payload_length, output ready);
endinterface

/* rtl/uart_command_frame_parser_unit.sv */
// Top level of the UART command frame parser (single module).
// Depends on ucfp_pkg, ucfp_in_if and ucfp_out_if.
//
// Usage:
//   i_item carries one transaction per received UART byte (mode 0) or per
//   millisecond tick (mode 1). o_result carries one event transaction for
//   every received byte: nothing, payload byte with its index, frame
//   accepted or frame rejected, with the held header fields. Ticks give no
//   result; they only age the idle counter, which saturates at timeout_ms.
//   A byte that arrives once the counter has reached the timeout first
//   drops any partial frame.
//   Each byte's event is registered and shows on o_result in the cycle
//   after the byte is accepted. Throughput: one transaction per cycle while
//   o_result is not stalled; the frame state machine and the result
//   register are updated in the same cycle, so no item waits for another.
//   Stall: the result register holds its event until taken; while it is
//   full and not being taken, i_item.ready is low. A taken result frees the
//   register in the same cycle, so back-to-back traffic keeps flowing.
//   Reset (i_rst_n low, synchronous): parser waits for a start byte,
//   running checksum and header are cleared, registers return to start 2,
//   end 3, timeout 1000 ms. The user must write configuration through
//   i_cfg_* only while no transaction is in flight; the block does not enforce this.
module uart_command_frame_parser_unit #(
    parameter int unsigned MAX_PAYLOAD = ucfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ucfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ucfp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    ucfp_in_if.sink                           i_item,
    ucfp_out_if.source                        o_result
);

    // Position counter must hold MAX_PAYLOAD itself
    localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned EXT_W = ucfp_pkg::LEN_W + 1;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        PH_START, PH_CMD, PH_DIR, PH_ERR, PH_LENL, PH_LENH, PH_DATA, PH_CHECK, PH_END
    } t_phase;

    // Configuration registers
    logic [ucfp_pkg::BYTE_W-1:0] r_start_byte;
    logic [ucfp_pkg::BYTE_W-1:0] r_end_byte;
    logic [ucfp_pkg::TMO_W-1:0]  r_timeout_ms;

    // Frame state
    t_phase                      r_phase, n_phase;
    logic [ucfp_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [ucfp_pkg::BYTE_W-1:0] r_check, n_check;
    logic [ucfp_pkg::BYTE_W-1:0] r_cmd, n_cmd;
    logic [ucfp_pkg::BYTE_W-1:0] r_dir, n_dir;
    logic [ucfp_pkg::BYTE_W-1:0] r_err, n_err;
    logic [ucfp_pkg::LEN_W-1:0]  r_len, n_len;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [ucfp_pkg::TMO_W-1:0]  r_idle, n_idle;

    // Result register
    logic                         r_out_valid, n_out_valid;
    logic [ucfp_pkg::EVENT_W-1:0] r_ev, n_ev;
    logic [ucfp_pkg::BYTE_W-1:0]  r_pbyte, n_pbyte;
    logic [ucfp_pkg::INDEX_W-1:0] r_pidx, n_pidx;
    logic [ucfp_pkg::BYTE_W-1:0]  r_ocmd, n_ocmd;
    logic [ucfp_pkg::BYTE_W-1:0]  r_odir, n_odir;
    logic [ucfp_pkg::BYTE_W-1:0]  r_oerr, n_oerr;
    logic [ucfp_pkg::LEN_W-1:0]   r_olen, n_olen;

    logic             in_ready;
    logic             in_fire;
    logic             byte_fire;
    t_phase           cur_phase;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] pos_inc;
    logic [ucfp_pkg::LEN_W-1:0] len_full;

    assign in_ready     = !r_out_valid || o_result.ready;
    assign i_item.ready = in_ready;
    assign in_fire      = i_item.valid && in_ready;
    assign byte_fire    = in_fire && (i_item.mode == ucfp_pkg::MODE_BYTE);

    assign pos_ext  = EXT_W'(r_pos);
    assign pos_inc  = pos_ext + EXT_W'(1);
    assign len_full = {i_item.rx_byte, r_len[ucfp_pkg::BYTE_W-1:0]};

    // Timeout forces resync before the byte is parsed
    assign cur_phase = (r_idle >= r_timeout_ms) ? PH_START : r_phase;

    // Next-state and result logic
    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_check     = r_check;
        n_cmd       = r_cmd;
        n_dir       = r_dir;
        n_err       = r_err;
        n_len       = r_len;
        n_pos       = r_pos;
        n_idle      = r_idle;
        n_out_valid = r_out_valid && !o_result.ready;
        n_ev        = r_ev;
        n_pbyte     = r_pbyte;
        n_pidx      = r_pidx;
        n_ocmd      = r_ocmd;
        n_odir      = r_odir;
        n_oerr      = r_oerr;
        n_olen      = r_olen;

        if (in_fire && (i_item.mode == ucfp_pkg::MODE_TICK)) begin
            if (r_idle < r_timeout_ms) begin
                n_idle = r_idle + ucfp_pkg::TMO_W'(1);
            end
        end

        if (byte_fire) begin
            n_idle  = '0;
            n_ev    = ucfp_pkg::EV_NONE;
            n_pbyte = '0;
            n_pidx  = '0;
            n_phase = cur_phase;
            case (cur_phase)
                PH_CMD: begin
                    n_cmd   = i_item.rx_byte;
                    n_xor   = r_xor ^ i_item.rx_byte;
                    n_phase = PH_DIR;
                end
                PH_DIR: begin
                    n_dir   = i_item.rx_byte;
                    n_xor   = r_xor ^ i_item.rx_byte;
                    n_phase = PH_ERR;
                end
                PH_ERR: begin
                    n_err   = i_item.rx_byte;
                    n_xor   = r_xor ^ i_item.rx_byte;
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    n_len   = ucfp_pkg::LEN_W'(i_item.rx_byte);
                    n_xor   = r_xor ^ i_item.rx_byte;
                    n_phase = PH_LENH;
                end
                PH_LENH: begin
                    n_len   = len_full;
                    n_xor   = r_xor ^ i_item.rx_byte;
                    n_pos   = '0;
                    n_phase = (len_full != '0) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    if (pos_ext < MAX_EXT) begin
                        n_ev    = ucfp_pkg::EV_DATA;
                        n_pbyte = i_item.rx_byte;
                        n_pidx  = pos_ext[ucfp_pkg::INDEX_W-1:0];
                        n_xor   = r_xor ^ i_item.rx_byte;
                        n_pos   = pos_inc[POS_W-1:0];
                        if (pos_inc == EXT_W'(r_len)) begin
                            n_phase = PH_CHECK;
                        end
                    end else begin
                        n_ev    = ucfp_pkg::EV_REJECT;
                        n_phase = PH_START;
                    end
                end
                PH_CHECK: begin
                    n_check = i_item.rx_byte;
                    n_phase = PH_END;
                end
                PH_END: begin
                    if ((i_item.rx_byte == r_end_byte) && (r_xor == r_check)) begin
                        n_ev = ucfp_pkg::EV_ACCEPT;
                    end else begin
                        n_ev = ucfp_pkg::EV_REJECT;
                    end
                    n_phase = PH_START;
                end
                default: begin
                    if (i_item.rx_byte == r_start_byte) begin
                        n_xor   = '0;
                        n_phase = PH_CMD;
                    end else begin
                        n_phase = PH_START;
                    end
                end
            endcase

            // Header goes out with every real event
            if (n_ev != ucfp_pkg::EV_NONE) begin
                n_ocmd = n_cmd;
                n_odir = n_dir;
                n_oerr = n_err;
                n_olen = n_len;
            end else begin
                n_ocmd = '0;
                n_odir = '0;
                n_oerr = '0;
                n_olen = '0;
            end
            n_out_valid = 1'b1;
        end
    end

    // State, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= ucfp_pkg::START_BYTE_RST;
            r_end_byte   <= ucfp_pkg::END_BYTE_RST;
            r_timeout_ms <= ucfp_pkg::TIMEOUT_RST;
            r_phase      <= PH_START;
            r_xor        <= '0;
            r_check      <= '0;
            r_cmd        <= '0;
            r_dir        <= '0;
            r_err        <= '0;
            r_len        <= '0;
            r_pos        <= '0;
            r_idle       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ucfp_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_wdata[ucfp_pkg::BYTE_W-1:0];
                    ucfp_pkg::CFG_END_BYTE:   r_end_byte   <= i_cfg_wdata[ucfp_pkg::BYTE_W-1:0];
                    ucfp_pkg::CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_wdata[ucfp_pkg::TMO_W-1:0];
                    default: ;
                endcase
            end
            r_phase     <= n_phase;
            r_xor       <= n_xor;
            r_check     <= n_check;
            r_cmd       <= n_cmd;
            r_dir       <= n_dir;
            r_err       <= n_err;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
        // Result payload, no reset needed
        r_ev    <= n_ev;
        r_pbyte <= n_pbyte;
        r_pidx  <= n_pidx;
        r_ocmd  <= n_ocmd;
        r_odir  <= n_odir;
        r_oerr  <= n_oerr;
        r_olen  <= n_olen;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.event_res      = r_ev;
    assign o_result.payload_byte   = r_pbyte;
    assign o_result.payload_index  = r_pidx;
    assign o_result.command_code   = r_ocmd;
    assign o_result.direction_code = r_odir;
    assign o_result.error_code     = r_oerr;
    assign o_result.payload_length = r_olen;

endmodule

/* tb/ucfp_frame_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the UART command frame parser: watches the item and result
// channels, predicts every event from the byte/tick stream and compares it.
// Depends on ucfp_pkg, ucfp_in_if and ucfp_out_if.
module ucfp_frame_checker
    import ucfp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ucfp_in_if                    i_item,
    ucfp_out_if                   i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked_count,
    output int                    o_accept_count,
    output int                    o_reject_count
);

    localparam int MAX_REPORTS = 10;

    typedef enum logic [3:0] {
        WAIT_START, GET_CMD, GET_DIR, GET_ERR, GET_LEN_LO, GET_LEN_HI,
        GET_DATA, GET_CHECK, GET_END
    } t_parse_phase;

    typedef struct packed {
        logic [EVENT_W-1:0] kind;
        logic [BYTE_W-1:0]  pbyte;
        logic [INDEX_W-1:0] pidx;
        logic [BYTE_W-1:0]  cmd;
        logic [BYTE_W-1:0]  dir;
        logic [BYTE_W-1:0]  err;
        logic [LEN_W-1:0]   len;
    } t_frame_event;

    // Predicted parser state and register copies
    t_parse_phase      phase;
    logic [BYTE_W-1:0] xor_acc;
    logic [BYTE_W-1:0] check_byte;
    logic [BYTE_W-1:0] hdr_cmd;
    logic [BYTE_W-1:0] hdr_dir;
    logic [BYTE_W-1:0] hdr_err;
    logic [LEN_W-1:0]  hdr_len;
    int unsigned       pay_pos;
    int unsigned       idle_ms;
    logic [BYTE_W-1:0] cfg_start;
    logic [BYTE_W-1:0] cfg_end;
    logic [TMO_W-1:0]  cfg_timeout;

    t_frame_event expected_events[$];
    int fail_cnt    = 0;
    int checked_cnt = 0;
    int accept_cnt  = 0;
    int reject_cnt  = 0;

    task automatic reset_parser();
        phase       = WAIT_START;
        xor_acc     = '0;
        check_byte  = '0;
        hdr_cmd     = '0;
        hdr_dir     = '0;
        hdr_err     = '0;
        hdr_len     = '0;
        pay_pos     = 0;
        idle_ms     = 0;
        cfg_start   = START_BYTE_RST;
        cfg_end     = END_BYTE_RST;
        cfg_timeout = TIMEOUT_RST;
        expected_events.delete();
    endtask

    // Advance the predicted parser by one transaction; bytes queue one event
    task automatic advance_parser(input logic mode, input logic [BYTE_W-1:0] b);
        t_frame_event ev;
        if (mode == MODE_TICK) begin
            if (idle_ms < cfg_timeout) idle_ms++;
        end else begin
            ev = '0;
            ev.kind = EV_NONE;
            // stale partial frame is dropped silently
            if (idle_ms >= cfg_timeout) phase = WAIT_START;
            idle_ms = 0;
            case (phase)
                GET_CMD: begin
                    hdr_cmd = b;
                    xor_acc ^= b;
                    phase = GET_DIR;
                end
                GET_DIR: begin
                    hdr_dir = b;
                    xor_acc ^= b;
                    phase = GET_ERR;
                end
                GET_ERR: begin
                    hdr_err = b;
                    xor_acc ^= b;
                    phase = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    hdr_len = {8'h00, b};
                    xor_acc ^= b;
                    phase = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    hdr_len[15:8] = b;
                    xor_acc ^= b;
                    pay_pos = 0;
                    phase = (hdr_len != 0) ? GET_DATA : GET_CHECK;
                end
                GET_DATA: begin
                    if (pay_pos < MAX_PAYLOAD) begin
                        ev.kind  = EV_DATA;
                        ev.pbyte = b;
                        ev.pidx  = pay_pos[INDEX_W-1:0];
                        xor_acc ^= b;
                        pay_pos++;
                        if (pay_pos == hdr_len) phase = GET_CHECK;
                    end else begin
                        // payload over capacity
                        ev.kind = EV_REJECT;
                        phase = WAIT_START;
                    end
                end
                GET_CHECK: begin
                    check_byte = b;
                    phase = GET_END;
                end
                GET_END: begin
                    ev.kind = (b == cfg_end && xor_acc == check_byte) ? EV_ACCEPT : EV_REJECT;
                    phase = WAIT_START;
                end
                default: begin
                    if (b == cfg_start) begin
                        xor_acc = '0;
                        phase = GET_CMD;
                    end else begin
                        phase = WAIT_START;
                    end
                end
            endcase
            if (ev.kind != EV_NONE) begin
                ev.cmd = hdr_cmd;
                ev.dir = hdr_dir;
                ev.err = hdr_err;
                ev.len = hdr_len;
            end
            expected_events.push_back(ev);
        end
    endtask

    // Compare one result transaction against the oldest prediction
    task automatic check_result();
        t_frame_event got;
        t_frame_event want;
        got = '{kind: i_result.event_res, pbyte: i_result.payload_byte,
                pidx: i_result.payload_index, cmd: i_result.command_code,
                dir: i_result.direction_code, err: i_result.error_code,
                len: i_result.payload_length};
        if (expected_events.size() == 0) begin
            if (fail_cnt < MAX_REPORTS)
                $display("[%0t] unexpected result: ev=%0d byte=%02h idx=%0d", $time,
                         got.kind, got.pbyte, got.pidx);
            fail_cnt++;
        end else begin
            want = expected_events.pop_front();
            checked_cnt++;
            if (want.kind == EV_ACCEPT) accept_cnt++;
            if (want.kind == EV_REJECT) reject_cnt++;
            if (got !== want) begin
                if (fail_cnt < MAX_REPORTS) begin
                    $display("[%0t] mismatch exp: ev=%0d byte=%02h idx=%0d cmd=%02h dir=%02h",
                             $time, want.kind, want.pbyte, want.pidx, want.cmd, want.dir,
                             " err=%02h len=%04h", want.err, want.len);
                    $display("[%0t]          got: ev=%0d byte=%02h idx=%0d cmd=%02h dir=%02h",
                             $time, got.kind, got.pbyte, got.pidx, got.cmd, got.dir,
                             " err=%02h len=%04h", got.err, got.len);
                end
                fail_cnt++;
            end
        end
    endtask

    // Results are checked before new items so a same-edge item never matches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BYTE: cfg_start   = i_cfg_wdata[BYTE_W-1:0];
                    CFG_END_BYTE:   cfg_end     = i_cfg_wdata[BYTE_W-1:0];
                    CFG_TIMEOUT_MS: cfg_timeout = i_cfg_wdata[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) check_result();
            if (i_item.valid && i_item.ready) advance_parser(i_item.mode, i_item.rx_byte);
        end
        o_pending       <= expected_events.size();
        o_fail_count    <= fail_cnt;
        o_checked_count <= checked_cnt;
        o_accept_count  <= accept_cnt;
        o_reject_count  <= reject_cnt;
    end

endmodule

/* tb/uart_command_frame_parser_unit_tb.sv */
`timescale 1ns / 100ps
// Top of the frame parser testbench: clock, reset, register writes, frame
// stimulus with random idling, watchdog and verdict.
// Depends on ucfp_pkg, both channel interfaces, the parser and ucfp_frame_checker.
module uart_command_frame_parser_unit_tb;
    import ucfp_pkg::*;

    localparam int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_SETTLE = 4;

    typedef enum int unsigned {
        FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_CUT, FRAME_OVERSIZE
    } t_frame_flaw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    ucfp_in_if  item_ch ();
    ucfp_out_if result_ch ();

    int fail_count;
    int pending;
    int checked_count;
    int accept_count;
    int reject_count;

    // Stimulus bookkeeping
    bit                idle_on;
    int unsigned       n_items_sent;
    int unsigned       n_bytes;
    int unsigned       n_ticks;
    int unsigned       quiet_cycles;
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;
    logic [TMO_W-1:0]  cur_timeout;
    logic [8:0]        directed_seq[$];

    uart_command_frame_parser_unit #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    ucfp_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item          (item_ch),
        .i_result        (result_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked_count (checked_count),
        .o_accept_count  (accept_count),
        .o_reject_count  (reject_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random stall bursts while idling is enabled
    initial begin
        result_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one item and hold it until the transaction completes
    task automatic send_item(input logic mode, input logic [BYTE_W-1:0] data);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= mode;
        item_ch.rx_byte <= data;
        do @(posedge i_clk); while (!item_ch.ready);
        n_items_sent++;
        if (mode == MODE_TICK) n_ticks++;
        else n_bytes++;
    endtask

    task automatic send_ticks(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) send_item(MODE_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] start_b,
                                input logic [BYTE_W-1:0] end_b,
                                input logic [TMO_W-1:0]  tmo);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_START_BYTE;
        i_cfg_wdata <= {8'h00, start_b};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_END_BYTE;
        i_cfg_wdata <= {8'h00, end_b};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TIMEOUT_MS;
        i_cfg_wdata <= tmo;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_start   = start_b;
        cur_end     = end_b;
        cur_timeout = tmo;
    endtask

    // One frame with random header and payload. hold_ticks is the idle stretch
    // after the cut point of a cut frame, or after the command byte otherwise.
    task automatic send_frame(input logic [LEN_W-1:0] len, input t_frame_flaw flaw,
                              input int unsigned hold_ticks);
        logic [BYTE_W-1:0] frame_q[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] val;
        int unsigned       n_pay;
        int unsigned       cut_at;
        int unsigned       cap;
        int unsigned       k;
        sum = '0;
        frame_q.push_back(cur_start);
        for (k = 0; k < 3; k++) begin
            val = BYTE_W'($urandom_range(0, 255));
            frame_q.push_back(val);
            sum ^= val;
        end
        frame_q.push_back(len[7:0]);
        frame_q.push_back(len[15:8]);
        sum ^= len[7:0] ^ len[15:8];
        n_pay = (flaw == FRAME_OVERSIZE) ? MAX_PAYLOAD + 1 : 32'(len);
        for (k = 0; k < n_pay; k++) begin
            val = BYTE_W'($urandom_range(0, 255));
            frame_q.push_back(val);
            sum ^= val;
        end
        if (flaw != FRAME_OVERSIZE) begin
            val = BYTE_W'($urandom_range(1, 255));
            frame_q.push_back((flaw == FRAME_BAD_SUM) ? sum ^ val : sum);
            frame_q.push_back((flaw == FRAME_BAD_END) ? cur_end ^ val : cur_end);
        end
        cut_at = (flaw == FRAME_CUT) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
        cap = (cur_timeout > 5) ? 4 : ((cur_timeout >= 2) ? cur_timeout - 1 : 0);
        for (k = 0; k < cut_at; k++) begin
            if (k == 2 && flaw != FRAME_CUT && hold_ticks != 0) begin
                send_ticks(hold_ticks);
            end else if (k > 0 && hold_ticks == 0 && cap != 0 && $urandom_range(0, 9) == 0) begin
                // short idle that stays under the timeout
                send_ticks($urandom_range(1, cap));
            end
            send_item(MODE_BYTE, frame_q[k]);
        end
        if (flaw == FRAME_CUT) send_ticks(hold_ticks);
    endtask

    // Mostly well-formed frames, some broken ones, noise and idle ticks
    task automatic run_mixed_traffic(input int unsigned n_items);
        int unsigned first;
        int unsigned pick;
        int unsigned len;
        int unsigned cap;
        int unsigned n_noise;
        int unsigned k;
        first = n_items_sent;
        while (n_items_sent - first < n_items) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            cap  = (cur_timeout + 2 < 64) ? cur_timeout + 2 : 64;
            if (pick < 60) begin
                send_frame(LEN_W'(len), FRAME_GOOD, 0);
            end else if (pick < 70) begin
                send_frame(LEN_W'(len), FRAME_BAD_SUM, 0);
            end else if (pick < 78) begin
                send_frame(LEN_W'(len), FRAME_BAD_END, 0);
            end else if (pick < 85) begin
                if (cur_timeout <= 64)
                    send_frame(LEN_W'(len), FRAME_CUT, cur_timeout + $urandom_range(0, 2));
                else
                    send_frame(LEN_W'(len), FRAME_BAD_SUM, 0);
            end else if (pick < 93) begin
                n_noise = $urandom_range(1, 4);
                for (k = 0; k < n_noise; k++) begin
                    if ($urandom_range(0, 3) == 0) send_item(MODE_BYTE, cur_start);
                    else send_item(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
                end
            end else if (pick < 99) begin
                send_ticks($urandom_range(1, cap));
            end else begin
                drain_results();
            end
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_START_BYTE;
        i_cfg_wdata     <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.mode    <= MODE_BYTE;
        item_ch.rx_byte <= '0;
        idle_on      = 1'b1;
        n_items_sent = 0;
        n_bytes      = 0;
        n_ticks      = 0;
        cur_start    = START_BYTE_RST;
        cur_end      = END_BYTE_RST;
        cur_timeout  = TIMEOUT_RST;
        // noise, zero-length good frame, one-byte frame with wrong end, ticks
        directed_seq = '{
            {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'hFF}, {MODE_BYTE, 8'h03},
            {MODE_BYTE, 8'h02}, {MODE_BYTE, 8'hFF}, {MODE_BYTE, 8'h00},
            {MODE_BYTE, 8'hA5}, {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'h00},
            {MODE_BYTE, 8'h5A}, {MODE_BYTE, 8'h03},
            {MODE_BYTE, 8'h02}, {MODE_BYTE, 8'h10}, {MODE_BYTE, 8'h20},
            {MODE_BYTE, 8'h30}, {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h00},
            {MODE_BYTE, 8'h7E}, {MODE_BYTE, 8'h7F}, {MODE_BYTE, 8'h04},
            {MODE_TICK, 8'hFF}, {MODE_TICK, 8'h00}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_seq[k]) send_item(directed_seq[k][8], directed_seq[k][7:0]);
        run_mixed_traffic(330);

        // timeout of one: a single tick between bytes drops the frame
        write_config(8'h00, 8'hFF, 16'd1);
        run_mixed_traffic(300);

        // highest timeout: a long idle inside a frame keeps it
        write_config(8'hFF, 8'h00, 16'hFFFF);
        send_frame(LEN_W'(4), FRAME_GOOD, 40);
        run_mixed_traffic(200);

        write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     TMO_W'($urandom_range(2, 12)));
        run_mixed_traffic(350);

        // zero timeout: every byte resynchronizes first
        write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     16'd0);
        run_mixed_traffic(50);

        // closing stretch at full rate
        write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     TMO_W'($urandom_range(2, 40)));
        idle_on = 1'b0;
        run_mixed_traffic(300);

        drain_results();
        $display("Sent %0d byte and %0d tick transactions; %0d results checked",
                 n_bytes, n_ticks, checked_count);
        $display("Frames accepted %0d, rejected %0d, over six register settings",
                 accept_count, reject_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
